### sv/dhcd_pkg.sv
// Shared types, constants and the sigmoid function for the cell decoder.
package dhcd_pkg;

    localparam int LogitW = 16;
    localparam int ProbW  = 16;

    localparam logic [1:0] CFG_OBJ_THR  = 2'd0;
    localparam logic [1:0] CFG_CONF_THR = 2'd1;
    localparam logic [1:0] CFG_RATIO_W  = 2'd2;
    localparam logic [1:0] CFG_RATIO_H  = 2'd3;

    typedef struct packed {
        logic [15:0] obj_thr;
        logic [15:0] conf_thr;
        logic [15:0] ratio_w;
        logic [15:0] ratio_h;
    } cfg_t;

    // Piecewise linear sigmoid, Q5.10 in, Q0.16 out, saturated to 65535.
    function automatic logic [15:0] sigmoid(input logic signed [15:0] x);
        logic [15:0] a;
        logic [16:0] y;
        logic [16:0] r;
        a = x[15] ? 16'(-x) : 16'(x);
        if (a >= 16'd5120)      y = 17'd65536;
        else if (a >= 16'd2432) y = 17'({a, 1'b0}) + 17'd55296;
        else if (a >= 16'd1024) y = 17'({a, 3'b000}) + 17'd40960;
        else                    y = 17'({a, 4'b0000}) + 17'd32768;
        r = x[15] ? 17'd65536 - y : y;
        return r[16] ? 16'hFFFF : r[15:0];
    endfunction

endpackage

### sv/detection_head_cell_decode.sv
// Top level of the detection head cell decoder: config registers and stream ports.
// One grid cell word per cycle is accepted while the output is not stalled; a kept
// cell's word becomes valid on the master side after passing every pipeline stage;
// a dropped cell produces no word. The five-stage pipeline (sigmoid and keep test,
// centre and square, anchor multiply, ratio multiply, truncate and saturate)
// advances whenever its output word is taken or empty, so the sustained rate is
// one cell per clock; a stalled output word holds the whole pipeline and the slave
// side.
module detection_head_cell_decode (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_logit, y_logit, w_logit, h_logit, obj_logit, class_zero_logit,
    // class_one_logit, grid_col, grid_row, level_stride, anchor_width,
    // anchor_height (lowest first), 155 bits padded to 160
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // class_id, score, box_left, box_top, box_width, box_height (lowest first),
    // 81 bits padded to 88
    output logic [87:0]  m_tdata
);
    import dhcd_pkg::*;

    cfg_t cfg_reg;

    // The user writes config only while idle, unenforced; no two-bit index is unknown.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{obj_thr: 16'd32768, conf_thr: 16'd32768,
                         ratio_w: 16'd256, ratio_h: 16'd256};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OBJ_THR:  cfg_reg.obj_thr  <= cfg_data;
                CFG_CONF_THR: cfg_reg.conf_thr <= cfg_data;
                CFG_RATIO_W:  cfg_reg.ratio_w  <= cfg_data;
                CFG_RATIO_H:  cfg_reg.ratio_h  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic        en, pv;
    logic [80:0] pd;

    // The pipe moves as a whole whenever its final word is absent or being taken.
    assign en       = !pv || m_tready;
    assign s_tready = en;
    assign m_tvalid = pv;
    assign m_tdata  = {7'd0, pd};

    dhcd_pipe u_pipe (
        .aclk, .aresetn, .en,
        .in_valid(s_tvalid), .cfg(cfg_reg),
        .x_logit(s_tdata[15:0]), .y_logit(s_tdata[31:16]),
        .w_logit(s_tdata[47:32]), .h_logit(s_tdata[63:48]),
        .obj_logit(s_tdata[79:64]), .c0_logit(s_tdata[95:80]),
        .c1_logit(s_tdata[111:96]), .grid_col(s_tdata[119:112]),
        .grid_row(s_tdata[127:120]), .level_stride(s_tdata[134:128]),
        .anchor_width(s_tdata[144:135]), .anchor_height(s_tdata[154:145]),
        .out_valid(pv), .out_data(pd)
    );

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready) else $error("accepted during stall");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[87:81] == 7'd0) else $error("pad bits set");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("ready low while empty");
`endif
endmodule

### sv/dhcd_pipe.sv
// Multi-stage datapath of the cell decoder with stall-capable valid chain.
module dhcd_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  dhcd_pkg::cfg_t      cfg,
    input  logic signed [15:0]  x_logit,
    input  logic signed [15:0]  y_logit,
    input  logic signed [15:0]  w_logit,
    input  logic signed [15:0]  h_logit,
    input  logic signed [15:0]  obj_logit,
    input  logic signed [15:0]  c0_logit,
    input  logic signed [15:0]  c1_logit,
    input  logic [7:0]          grid_col,
    input  logic [7:0]          grid_row,
    input  logic [6:0]          level_stride,
    input  logic [9:0]          anchor_width,
    input  logic [9:0]          anchor_height,
    output logic                out_valid,
    output logic [80:0]         out_data
);
    import dhcd_pkg::*;

    // Stage 1: sigmoids, keep decision.
    logic              v1_reg, cls1_reg;
    logic [15:0]       px1_reg, py1_reg, pw1_reg, ph1_reg, best1_reg;
    logic [7:0]        col1_reg, row1_reg;
    logic [6:0]        st1_reg;
    logic [9:0]        aw1_reg, ah1_reg;
    logic [15:0]       pobj, pc0, pc1, best;
    logic              cls, keep;

    always_comb begin
        pobj = sigmoid(obj_logit);
        pc0  = sigmoid(c0_logit);
        pc1  = sigmoid(c1_logit);
        cls  = pc1 > pc0;
        best = cls ? pc1 : pc0;
        keep = (pobj > cfg.obj_thr) && (best > cfg.conf_thr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid && keep;
        end
        if (en) begin
            cls1_reg <= cls;       best1_reg <= best;
            px1_reg <= sigmoid(x_logit); py1_reg <= sigmoid(y_logit);
            pw1_reg <= sigmoid(w_logit); ph1_reg <= sigmoid(h_logit);
            col1_reg <= grid_col;  row1_reg <= grid_row; st1_reg <= level_stride;
            aw1_reg <= anchor_width; ah1_reg <= anchor_height;
        end
    end

    // Stage 2: centres times stride, squared extents.
    logic              v2_reg, cls2_reg;
    logic [15:0]       best2_reg;
    logic signed [31:0] cx2_reg, cy2_reg;
    logic [33:0]       tw2_reg, th2_reg;
    logic [9:0]        aw2_reg, ah2_reg;
    logic signed [25:0] ox, oy;
    logic [16:0]       tw, th;

    always_comb begin
        ox = 26'sd0 + $signed({9'd0, px1_reg, 1'b0}) - 26'sd32768
            + $signed({2'd0, col1_reg, 16'd0});
        oy = 26'sd0 + $signed({9'd0, py1_reg, 1'b0}) - 26'sd32768
            + $signed({2'd0, row1_reg, 16'd0});
        tw = {pw1_reg, 1'b0};
        th = {ph1_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            cls2_reg <= cls1_reg; best2_reg <= best1_reg;
            cx2_reg <= 32'(ox * $signed({1'b0, st1_reg}));
            cy2_reg <= 32'(oy * $signed({1'b0, st1_reg}));
            tw2_reg <= tw * tw;
            th2_reg <= th * th;
            aw2_reg <= aw1_reg; ah2_reg <= ah1_reg;
        end
    end

    // Stage 3: extents times anchor, floored to Q16.
    logic              v3_reg, cls3_reg;
    logic [15:0]       best3_reg;
    logic signed [31:0] cx3_reg, cy3_reg;
    logic [27:0]       wq3_reg, hq3_reg;
    logic [43:0]       wfull, hfull;

    always_comb begin
        wfull = tw2_reg * aw2_reg;
        hfull = th2_reg * ah2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            cls3_reg <= cls2_reg; best3_reg <= best2_reg;
            cx3_reg <= cx2_reg; cy3_reg <= cy2_reg;
            wq3_reg <= wfull[43:16];
            hq3_reg <= hfull[43:16];
        end
    end

    // Stage 4: doubled centres minus extents, then ratio scaling.
    logic              v4_reg, cls4_reg;
    logic [15:0]       best4_reg;
    logic signed [50:0] dx4_reg, dy4_reg;
    logic [43:0]       sw4_reg, sh4_reg;
    logic signed [33:0] ex, ey;

    always_comb begin
        ex = 34'(cx3_reg) * 34'sd2 - $signed({6'd0, wq3_reg});
        ey = 34'(cy3_reg) * 34'sd2 - $signed({6'd0, hq3_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            cls4_reg <= cls3_reg; best4_reg <= best3_reg;
            dx4_reg <= 51'(ex * $signed({1'b0, cfg.ratio_w}));
            dy4_reg <= 51'(ey * $signed({1'b0, cfg.ratio_h}));
            sw4_reg <= wq3_reg * cfg.ratio_w;
            sh4_reg <= hq3_reg * cfg.ratio_h;
        end
    end

    // Stage 5: truncate toward zero and saturate.
    function automatic logic [15:0] sat_s(input logic signed [50:0] d);
        logic [50:0] m;
        logic [25:0] q;
        m = d[50] ? 51'(-d) : 51'(d);
        q = m[50:25];
        if (d[50]) return (q > 26'd32768) ? 16'h8000 : 16'(-q);
        return (q > 26'd32767) ? 16'h7FFF : q[15:0];
    endfunction

    function automatic logic [15:0] sat_u(input logic [43:0] s);
        return (s[43:24] > 20'd65535) ? 16'hFFFF : s[39:24];
    endfunction

    logic        v5_reg;
    logic [80:0] d5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            d5_reg <= {sat_u(sh4_reg), sat_u(sw4_reg), sat_s(dy4_reg),
                       sat_s(dx4_reg), best4_reg, cls4_reg};
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = d5_reg;

`ifndef SYNTHESIS
    a_v_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v3_reg |=> v4_reg) else $error("valid lost in pipe");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en && v5_reg |=> v5_reg && $stable(d5_reg)) else $error("stall lost data");
    a_score: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> best1_reg != 16'd0) else $error("zero score kept");
`endif
endmodule
